[design/pha_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Per-host admission package
// Shared widths, codes and class tables for the per-host admission block.
// ----------------------------------------------------------------------------
package pha_pkg;

    localparam int HOST_SLOTS_DEF    = 16;
    localparam int PERMIT_SLOTS_DEF  = 64;
    localparam int DEFAULT_LEVEL_DEF = 6;
    localparam int PENALTY_CAP_DEF   = 16;

    localparam logic [2:0] ACT_ACQUIRE = 3'd0;
    localparam logic [2:0] ACT_RELEASE = 3'd1;
    localparam logic [2:0] ACT_REPORT  = 3'd2;
    localparam logic [2:0] ACT_MIGRATE = 3'd3;
    localparam logic [2:0] ACT_QUERY   = 3'd4;

    localparam logic [2:0] OC_SUCCESS = 3'd0;
    localparam logic [2:0] OC_RESET   = 3'd3;
    localparam logic [2:0] OC_RATE    = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [3:0] CLS_PINNED = 4'd11;

    localparam logic [2:0] CFG_NORMAL_LEVEL = 3'd0;
    localparam logic [2:0] CFG_GLOBAL_CAP   = 3'd1;
    localparam logic [2:0] CFG_BULK_CAP     = 3'd2;
    localparam logic [2:0] CFG_COLD_START   = 3'd3;
    localparam logic [2:0] CFG_SUCC_STEP    = 3'd4;
    localparam logic [2:0] CFG_MIN_COOL     = 3'd5;
    localparam logic [2:0] CFG_MAX_COOL     = 3'd6;
    localparam logic [2:0] CFG_UNK_CEIL     = 3'd7;

    typedef struct packed {
        logic [2:0]  normal_level;
        logic [6:0]  global_cap;
        logic [6:0]  bulk_cap;
        logic [4:0]  cold_start_level;
        logic [7:0]  successes_per_step;
        logic [15:0] min_cooldown_ms;
        logic [23:0] max_cooldown_ms;
        logic [4:0]  unknown_ceiling;
    } t_cfg;

    // Command from controller to datapath.
    typedef struct packed {
        logic capture;  // latch the request and read host/permit entries
        logic execute;  // compute and write back, load result
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_stat;

    // Hard ceiling of a host class.
    function automatic logic [4:0] hard_ceiling(input logic [3:0] cls,
                                                input logic [4:0] unk);
        logic [4:0] r;
        begin
            case (cls)
                4'd1, 4'd3, 4'd4: r = 5'd16;
                4'd2: r = 5'd12;
                4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: r = 5'd4;
                4'd11: r = 5'd1;
                default: r = unk;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[design/pha_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Per-host admission channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pha_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [3:0]         host_id;
    logic [3:0]         host_class;
    logic               latency_critical;
    logic [5:0]         permit_in;
    logic [2:0]         outcome;
    logic signed [16:0] retry_after_s;
    logic [31:0]        now_ms;
    modport source (output valid, action, host_id, host_class, latency_critical,
                    permit_in, outcome, retry_after_s, now_ms, input ready);
    modport sink (input valid, action, host_id, host_class, latency_critical,
                  permit_in, outcome, retry_after_s, now_ms, output ready);
endinterface

interface pha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  permit_out;
    logic [4:0]  host_limit;
    logic [6:0]  host_in_flight;
    logic [23:0] cooldown_left_ms;
    logic [6:0]  total_in_flight;
    modport source (output valid, status, permit_out, host_limit, host_in_flight,
                    cooldown_left_ms, total_in_flight, input ready);
    modport sink (input valid, status, permit_out, host_limit, host_in_flight,
                  cooldown_left_ms, total_in_flight, output ready);
endinterface

interface pha_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/pha_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Per-host admission controller
// Sequences capture, execute and result delivery for one request at a time.
// ----------------------------------------------------------------------------
module pha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire logic          i_out_busy,
    output pha_pkg::t_cmd      o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // A new request is taken only when the result register is free.
    assign o_req_ready = (r_state == S_IDLE) && !i_out_busy;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && !i_out_busy) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[design/pha_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Per-host admission datapath
// Host and permit tables, the lowest-free-slot search and the AIMD update.
// ----------------------------------------------------------------------------
module pha_dp #(
    parameter int HOST_SLOTS    = pha_pkg::HOST_SLOTS_DEF,
    parameter int PERMIT_SLOTS  = pha_pkg::PERMIT_SLOTS_DEF,
    parameter int DEFAULT_LEVEL = pha_pkg::DEFAULT_LEVEL_DEF,
    parameter int PENALTY_CAP   = pha_pkg::PENALTY_CAP_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire pha_pkg::t_cmd i_cmd,
    input  wire pha_pkg::t_cfg i_cfg,
    pha_req_if.sink           req,
    pha_rsp_if.source         rsp,
    output pha_pkg::t_stat    o_stat
);
    localparam int HW = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
    localparam int PW = (PERMIT_SLOTS > 1) ? $clog2(PERMIT_SLOTS) : 1;
    localparam int LW = $clog2(DEFAULT_LEVEL + 1);
    // Rounded-up division by the default level is done as a multiplication by
    // a reciprocal; the numerator stays below 512, where this is exact.
    localparam int RECIP_SH = 18;
    localparam int RECIP_M  = (1 << RECIP_SH) / DEFAULT_LEVEL + 1;

    // Host table, one entry per host slot.
    logic                r_hvalid [HOST_SLOTS];
    logic [3:0]          r_hkind  [HOST_SLOTS];
    logic [4:0]          r_hlevel [HOST_SLOTS];
    logic [6:0]          r_hbusy  [HOST_SLOTS];
    logic [7:0]          r_hclean [HOST_SLOTS];
    logic [4:0]          r_hpen   [HOST_SLOTS];
    logic [32:0]         r_hcool  [HOST_SLOTS];
    // Permit table.
    logic                r_pvalid [PERMIT_SLOTS];
    logic [HW-1:0]       r_phost  [PERMIT_SLOTS];
    logic                r_purg   [PERMIT_SLOTS];
    logic [6:0]          r_all, r_bulk;

    // Captured request.
    logic [2:0]  r_act;
    logic [HW-1:0] r_h;
    logic [3:0]  r_cls;
    logic        r_lat;
    logic [5:0]  r_pin;
    logic [2:0]  r_oc;
    logic        r_has_retry;
    logic [31:0] r_now;
    // Values read during capture.
    logic        r_pin_ok;
    logic [HW-1:0] r_ph;
    logic        r_purg_rd;
    logic        r_free_ok;
    logic [PW-1:0] r_free;
    logic [4:0]  r_scaled [12];  // per class, scaled ceilings
    logic [39:0] r_retry_ms;

    // Result register.
    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [5:0]  r_pout;
    logic [4:0]  r_lim;
    logic [6:0]  r_busy_o;
    logic [23:0] r_left;

    assign o_stat.busy = r_ovalid && !rsp.ready;
    assign rsp.valid = r_ovalid;
    assign rsp.status = r_status;
    assign rsp.permit_out = r_pout;
    assign rsp.host_limit = r_lim;
    assign rsp.host_in_flight = r_busy_o;
    assign rsp.cooldown_left_ms = r_left;
    assign rsp.total_in_flight = r_all;

    // Clamped normal level.
    logic [LW-1:0] lvl;
    always_comb begin
        if (i_cfg.normal_level == 3'd0) lvl = LW'(1);
        else if (32'(i_cfg.normal_level) > DEFAULT_LEVEL) lvl = LW'(DEFAULT_LEVEL);
        else lvl = LW'(i_cfg.normal_level);
    end

    // Ceiling scaled by the level, rounded up, kept within 1..hard.
    function automatic logic [4:0] scale_ceil(input logic [4:0] hard,
                                              input logic [LW-1:0] lv);
        logic [9:0]  num;
        logic [27:0] prod;
        logic [9:0]  s;
        begin
            num  = 10'(hard) * 10'(lv) + 10'(DEFAULT_LEVEL - 1);
            prod = 28'(num) * 28'(RECIP_M);
            s    = 10'(prod >> RECIP_SH);
            if (s > 10'(hard)) s = 10'(hard);
            if (s == 10'd0) s = 10'd1;
            return s[4:0];
        end
    endfunction

    function automatic logic [4:0] scaled_of(input logic [3:0] c, input logic [4:0] sc [12]);
        begin
            if (c == pha_pkg::CLS_PINNED) return 5'd1;
            if (c > 4'd11) return sc[0];
            return sc[c];
        end
    endfunction

    // Lowest free permit slot, searched at capture.
    logic          free_ok;
    logic [PW-1:0] free_idx;
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int p = PERMIT_SLOTS - 1; p >= 0; p--) begin
            if (!r_pvalid[p]) begin
                free_ok  = 1'b1;
                free_idx = PW'(p);
            end
        end
    end

    // Host id folded onto the host slots by a small constant table.
    logic [HW-1:0] req_h;
    always_comb begin
        req_h = '0;
        for (int v = 0; v < 16; v++) begin
            if (req.host_id == 4'(v)) req_h = HW'(v % HOST_SLOTS);
        end
    end

    // Execute-phase combinational update.
    logic [4:0]  sc_req, sc_ph, sc_tgt;
    logic        urgent;
    logic [HW-1:0] tgt;          // host updated by outcome/open
    logic        open_h;         // create r_h
    logic        t_valid;
    logic [3:0]  t_kind;
    logic [4:0]  t_level;
    logic [6:0]  t_busy;
    logic [7:0]  t_clean;
    logic [4:0]  t_pen;
    logic [32:0] t_cool;
    logic        wr_tgt;
    logic        do_oc;
    logic [2:0]  oc_eff;
    logic        has_r;
    logic [4:0]  t_elim;
    logic        grant;
    logic        src_dec;        // migrate: decrement source host
    logic [1:0]  status;
    logic [HW-1:0] rep_h;
    logic [4:0]  fresh;
    logic [47:0] cd;
    logic [32:0] cool_end;
    logic [4:0]  sh;
    logic [4:0]  lim_o;
    logic [6:0]  busy_o;
    logic [23:0] left_o;
    logic [32:0] diff;

    always_comb begin
        sc_req = scaled_of(r_cls, r_scaled);
        fresh  = (r_cls == pha_pkg::CLS_PINNED) ? 5'd1 :
                 ((i_cfg.cold_start_level < sc_req) ? i_cfg.cold_start_level : sc_req);
        urgent = r_lat || (r_cls >= 4'd5 && r_cls <= 4'd7);
        status = pha_pkg::ST_DONE;
        grant  = 1'b0;
        src_dec = 1'b0;
        do_oc  = 1'b0;
        oc_eff = r_oc;
        has_r  = 1'b0;
        open_h = 1'b0;
        tgt    = r_h;
        rep_h  = r_h;
        case (r_act)
            pha_pkg::ACT_ACQUIRE: begin
                status = pha_pkg::ST_REFUSED;
                open_h = (r_all < i_cfg.global_cap) && (urgent || r_bulk < i_cfg.bulk_cap);
            end
            pha_pkg::ACT_RELEASE: begin
                if (!r_pin_ok) status = pha_pkg::ST_UNKNOWN;
                else begin
                    tgt = r_ph;
                    rep_h = r_ph;
                    do_oc = r_hvalid[r_ph];
                end
            end
            pha_pkg::ACT_REPORT: begin
                open_h = 1'b1;
                do_oc  = 1'b1;
                oc_eff = pha_pkg::OC_RATE;
                has_r  = r_has_retry;
            end
            pha_pkg::ACT_MIGRATE: begin
                if (!r_pin_ok) status = pha_pkg::ST_UNKNOWN;
                else if (r_ph != r_h) begin
                    open_h  = 1'b1;
                    src_dec = r_hvalid[r_ph] && (r_hbusy[r_ph] != 7'd0);
                end
            end
            default: ;
        endcase

        // Load target entry, opening it if needed.
        if (open_h && !r_hvalid[tgt]) begin
            t_valid = 1'b1; t_kind = r_cls; t_level = fresh; t_busy = 7'd0;
            t_clean = 8'd0; t_pen = 5'd0; t_cool = 33'd0;
        end else begin
            t_valid = r_hvalid[tgt]; t_kind = r_hkind[tgt]; t_level = r_hlevel[tgt];
            t_busy = r_hbusy[tgt]; t_clean = r_hclean[tgt]; t_pen = r_hpen[tgt];
            t_cool = r_hcool[tgt];
        end
        sc_tgt = scaled_of(t_kind, r_scaled);
        sc_ph  = sc_tgt;
        t_elim = (t_kind == pha_pkg::CLS_PINNED) ? 5'd1 :
                 ((t_level > sc_tgt) ? sc_tgt : ((t_level == 5'd0) ? 5'd1 : t_level));

        if (r_act == pha_pkg::ACT_ACQUIRE && open_h) begin
            if (t_cool <= {1'b0, r_now} && {2'b0, t_busy} < 9'(t_elim) && r_free_ok) begin
                grant  = 1'b1;
                status = pha_pkg::ST_DONE;
                t_busy = t_busy + 7'd1;
            end
        end
        if (r_act == pha_pkg::ACT_MIGRATE && open_h) t_busy = t_busy + 7'd1;
        if (r_act == pha_pkg::ACT_RELEASE && do_oc && t_busy != 7'd0) t_busy = t_busy - 7'd1;

        // Outcome.
        sh = (t_pen < 5'(PENALTY_CAP)) ? t_pen : 5'(PENALTY_CAP);
        cd = has_r ? 48'(r_retry_ms) : (48'(i_cfg.min_cooldown_ms) << sh);
        if (cd > 48'(i_cfg.max_cooldown_ms)) cd = 48'(i_cfg.max_cooldown_ms);
        cool_end = {1'b0, r_now} + 33'(cd);
        if (do_oc) begin
            if (oc_eff == pha_pkg::OC_SUCCESS) begin
                if (t_kind != pha_pkg::CLS_PINNED) begin
                    if (t_clean + 8'd1 >= i_cfg.successes_per_step) begin
                        t_clean = 8'd0;
                        t_pen   = 5'd0;
                        if (t_level < sc_ph) t_level = t_level + 5'd1;
                    end else t_clean = t_clean + 8'd1;
                end
            end else if (oc_eff == pha_pkg::OC_RESET || oc_eff == pha_pkg::OC_RATE) begin
                t_clean = 8'd0;
                if (t_kind != pha_pkg::CLS_PINNED) begin
                    t_level = t_level >> 1;
                    if (t_level == 5'd0) t_level = 5'd1;
                end
                if (oc_eff == pha_pkg::OC_RATE) begin
                    t_pen = (6'(t_pen) + 6'd1 < 6'(PENALTY_CAP)) ? t_pen + 5'd1 :
                            5'(PENALTY_CAP);
                    if (cool_end > t_cool) t_cool = cool_end;
                end
            end
        end
        wr_tgt = open_h || do_oc;

        // Report the addressed host after the step (source and target differ only
        // when migrating, where the reported host is the target).
        t_elim = (t_kind == pha_pkg::CLS_PINNED) ? 5'd1 :
                 ((t_level > sc_tgt) ? sc_tgt : ((t_level == 5'd0) ? 5'd1 : t_level));
        diff = t_cool - {1'b0, r_now};
        if (t_valid && rep_h == tgt) begin
            lim_o  = t_elim;
            busy_o = t_busy;
            left_o = (t_cool > {1'b0, r_now}) ?
                     ((diff > 33'hFF_FFFF) ? 24'hFF_FFFF : diff[23:0]) : 24'd0;
        end else begin
            lim_o  = (fresh == 5'd0) ? 5'd1 : fresh;
            busy_o = 7'd0;
            left_o = 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_all    <= 7'd0;
            r_bulk   <= 7'd0;
            for (int i = 0; i < HOST_SLOTS; i++) r_hvalid[i] <= 1'b0;
            for (int i = 0; i < PERMIT_SLOTS; i++) r_pvalid[i] <= 1'b0;
        end else begin
            if (i_cmd.execute) r_ovalid <= 1'b1;
            else if (rsp.ready) r_ovalid <= 1'b0;
            if (i_cmd.capture) begin
                r_act <= req.action;
                r_h   <= req_h;
                r_cls <= req.host_class;
                r_lat <= req.latency_critical;
                r_pin <= req.permit_in;
                r_oc  <= req.outcome;
                r_has_retry <= !req.retry_after_s[16];
                r_retry_ms <= 40'(req.retry_after_s[15:0]) * 40'd1000;
                r_now <= req.now_ms;
                r_pin_ok <= (32'(req.permit_in) < PERMIT_SLOTS) &&
                            r_pvalid[PW'(req.permit_in)];
                r_ph <= r_phost[PW'(req.permit_in)];
                r_purg_rd <= r_purg[PW'(req.permit_in)];
                r_free_ok <= free_ok;
                r_free <= free_idx;
                for (int c = 0; c < 12; c++) begin
                    r_scaled[c] <= scale_ceil(
                        pha_pkg::hard_ceiling(4'(c), i_cfg.unknown_ceiling), lvl);
                end
            end
            if (i_cmd.execute) begin
                if (wr_tgt) begin
                    r_hvalid[tgt] <= t_valid;
                    r_hkind[tgt]  <= t_kind;
                    r_hlevel[tgt] <= t_level;
                    r_hbusy[tgt]  <= t_busy;
                    r_hclean[tgt] <= t_clean;
                    r_hpen[tgt]   <= t_pen;
                    r_hcool[tgt]  <= t_cool;
                end
                if (src_dec) r_hbusy[r_ph] <= r_hbusy[r_ph] - 7'd1;
                if (grant) begin
                    r_pvalid[r_free] <= 1'b1;
                    r_phost[r_free]  <= r_h;
                    r_purg[r_free]   <= urgent;
                    r_all <= r_all + 7'd1;
                    if (!urgent) r_bulk <= r_bulk + 7'd1;
                end
                if (r_act == pha_pkg::ACT_RELEASE && r_pin_ok) begin
                    r_pvalid[PW'(r_pin)] <= 1'b0;
                    if (r_all != 7'd0) r_all <= r_all - 7'd1;
                    if (!r_purg_rd && r_bulk != 7'd0) r_bulk <= r_bulk - 7'd1;
                end
                if (r_act == pha_pkg::ACT_MIGRATE && r_pin_ok) r_phost[PW'(r_pin)] <= r_h;
                r_status <= status;
                r_pout   <= grant ? 6'(r_free) : 6'd0;
                r_lim    <= lim_o;
                r_busy_o <= busy_o;
                r_left   <= left_o;
            end
        end
    end
endmodule
`default_nettype wire

[design/pha_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Per-host admission configuration registers
// Holds the eight configuration registers written through the config channel.
// ----------------------------------------------------------------------------
module pha_cfg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pha_cfg_if.sink        cfg,
    output pha_pkg::t_cfg  o_cfg
);
    pha_pkg::t_cfg r_cfg;
    assign cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_level       <= 3'd6;
            r_cfg.global_cap         <= 7'd32;
            r_cfg.bulk_cap           <= 7'd24;
            r_cfg.cold_start_level   <= 5'd2;
            r_cfg.successes_per_step <= 8'd4;
            r_cfg.min_cooldown_ms    <= 16'd1000;
            r_cfg.max_cooldown_ms    <= 24'd60000;
            r_cfg.unknown_ceiling    <= 5'd4;
        end else if (cfg.valid) begin
            case (cfg.index)
                pha_pkg::CFG_NORMAL_LEVEL: r_cfg.normal_level <= cfg.data[2:0];
                pha_pkg::CFG_GLOBAL_CAP:   r_cfg.global_cap <= cfg.data[6:0];
                pha_pkg::CFG_BULK_CAP:     r_cfg.bulk_cap <= cfg.data[6:0];
                pha_pkg::CFG_COLD_START:   r_cfg.cold_start_level <= cfg.data[4:0];
                pha_pkg::CFG_SUCC_STEP:    r_cfg.successes_per_step <= cfg.data[7:0];
                pha_pkg::CFG_MIN_COOL:     r_cfg.min_cooldown_ms <= cfg.data[15:0];
                pha_pkg::CFG_MAX_COOL:     r_cfg.max_cooldown_ms <= cfg.data[23:0];
                pha_pkg::CFG_UNK_CEIL:     r_cfg.unknown_ceiling <= cfg.data[4:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/per_host_aimd_admission.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Per-host AIMD admission
// Grants permit slots per host with additive increase, multiplicative decrease
// and rate-limit cooldowns.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req       in         action, host, class, urgency, permit, outcome, retry, time
//  rsp       out        status, permit, host limit, in flight, cooldown, total
//  cfg       in         register index and write data, always ready
//
// Each request passes through a capture step that latches the request, reads
// the permit entry and finds the lowest free permit slot, followed by an execute step
// that updates the host entry and loads the result register. A new request is
// taken once the result register is empty or being drained, so a stalled result
// holds the input off. Reset is synchronous and clears all valid bits and counts.
// ----------------------------------------------------------------------------
module per_host_aimd_admission #(
    parameter int HOST_SLOTS    = pha_pkg::HOST_SLOTS_DEF,
    parameter int PERMIT_SLOTS  = pha_pkg::PERMIT_SLOTS_DEF,
    parameter int DEFAULT_LEVEL = pha_pkg::DEFAULT_LEVEL_DEF,
    parameter int PENALTY_CAP   = pha_pkg::PENALTY_CAP_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pha_req_if.sink    req,
    pha_rsp_if.source  rsp,
    pha_cfg_if.sink    cfg
);
    pha_pkg::t_cfg  cfg_q;
    pha_pkg::t_cmd  cmd;
    pha_pkg::t_stat stat;
    logic           req_ready;

    assign req.ready = req_ready;

    pha_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg),
        .o_cfg   (cfg_q)
    );

    pha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req.valid),
        .o_req_ready (req_ready),
        .i_out_busy  (stat.busy),
        .o_cmd       (cmd)
    );

    pha_dp #(
        .HOST_SLOTS    (HOST_SLOTS),
        .PERMIT_SLOTS  (PERMIT_SLOTS),
        .DEFAULT_LEVEL (DEFAULT_LEVEL),
        .PENALTY_CAP   (PENALTY_CAP)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg_q),
        .req     (req),
        .rsp     (rsp),
        .o_stat  (stat)
    );
endmodule
`default_nettype wire
